// ===== sv/dfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_pkg: shared types and constants for the delimited frame parser
// Parse phases, event and error codes, register indexes and the structs that
// carry configuration and results between the parser modules.
// ----------------------------------------------------------------------------
package dfp_pkg;

  // Address, command, length, CRC low, CRC high, end and start bytes.
  localparam int unsigned FrameOverhead = 7;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRCL,
    PH_CRCH,
    PH_END
  } phase_e;

  typedef enum logic [1:0] {
    EV_PAYLOAD,
    EV_FRAME,
    EV_ERROR
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_OVERFLOW,
    ERR_PAYLOAD_LONG,
    ERR_FRAME_LARGE,
    ERR_BAD_END
  } error_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_ADDRESS,
    REG_BROADCAST_ADDRESS,
    REG_START_MARKER,
    REG_END_MARKER,
    REG_PAYLOAD_LIMIT,
    REG_FRAME_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] broadcast_address;
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] payload_limit;
    logic [8:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    event_kind_e kind;
    logic [7:0]  data_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_address;
    logic [7:0]  frame_command;
    logic [7:0]  frame_length;
    logic [15:0] received_crc;
    error_code_e error_code;
    logic [31:0] error_total;
  } result_t;

endpackage

// ===== sv/dfp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_cfg_regs: configuration register file
// Holds addresses, markers and limits; written through a plain write port.
// ----------------------------------------------------------------------------
module dfp_cfg_regs
  import dfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OWN_ADDRESS:       cfg_d.own_address       = cfg_wdata_i[7:0];
        REG_BROADCAST_ADDRESS: cfg_d.broadcast_address = cfg_wdata_i[7:0];
        REG_START_MARKER:      cfg_d.start_marker      = cfg_wdata_i[7:0];
        REG_END_MARKER:        cfg_d.end_marker        = cfg_wdata_i[7:0];
        REG_PAYLOAD_LIMIT:     cfg_d.payload_limit     = cfg_wdata_i[7:0];
        REG_FRAME_LIMIT:       cfg_d.frame_limit       = cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address       <= 8'd1;
      cfg_q.broadcast_address <= 8'd0;
      cfg_q.start_marker      <= 8'd126;
      cfg_q.end_marker        <= 8'd127;
      cfg_q.payload_limit     <= 8'd128;
      cfg_q.frame_limit       <= 9'd160;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/dfp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_core: frame parse state machine
// Advances the parse state by one byte per step and forms the result of it.
// ----------------------------------------------------------------------------
module dfp_core
  import dfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [8:0]  bytes_q, bytes_d;
  logic [7:0]  exp_q, exp_d;
  logic [7:0]  pcnt_q, pcnt_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] crc_q, crc_d;
  logic [31:0] err_cnt_q, err_cnt_d;

  logic        overflow;
  logic        too_large;
  logic        do_clear;
  logic [31:0] err_cnt_inc;

  assign overflow    = ({1'b0, bytes_q} + 10'd1) >= {1'b0, cfg_i.frame_limit};
  assign too_large   = (10'(FrameOverhead) + {2'b00, byte_i}) > {1'b0, cfg_i.frame_limit};
  assign err_cnt_inc = err_cnt_q + 32'd1;

  always_comb begin
    phase_d   = phase_q;
    bytes_d   = bytes_q;
    exp_d     = exp_q;
    pcnt_d    = pcnt_q;
    addr_d    = addr_q;
    cmd_d     = cmd_q;
    crc_d     = crc_q;
    err_cnt_d = err_cnt_q;
    do_clear  = 1'b0;

    res_o.emit          = 1'b0;
    res_o.kind          = EV_PAYLOAD;
    res_o.data_byte     = '0;
    res_o.payload_index = '0;
    res_o.frame_address = addr_q;
    res_o.frame_command = cmd_q;
    res_o.frame_length  = exp_q;
    res_o.received_crc  = '0;
    res_o.error_code    = ERR_OVERFLOW;
    res_o.error_total   = err_cnt_q;

    if (overflow) begin
      // The byte is dropped and the frame abandoned, in any phase.
      res_o.emit        = 1'b1;
      res_o.kind        = EV_ERROR;
      res_o.error_total = err_cnt_inc;
      err_cnt_d         = err_cnt_inc;
      do_clear          = 1'b1;
    end else if (phase_q == PH_HUNT) begin
      if (byte_i == cfg_i.start_marker) begin
        bytes_d = 9'd1;
        phase_d = PH_ADDR;
      end
    end else begin
      bytes_d = bytes_q + 9'd1;
      unique case (phase_q)
        PH_ADDR: begin
          addr_d = byte_i;
          if (byte_i != cfg_i.own_address && byte_i != cfg_i.broadcast_address) begin
            do_clear = 1'b1;
          end else begin
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d   = byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          exp_d              = byte_i;
          pcnt_d             = '0;
          res_o.frame_length = byte_i;
          if (byte_i > cfg_i.payload_limit || too_large) begin
            res_o.emit        = 1'b1;
            res_o.kind        = EV_ERROR;
            res_o.error_code  = (byte_i > cfg_i.payload_limit) ? ERR_PAYLOAD_LONG
                                                               : ERR_FRAME_LARGE;
            res_o.error_total = err_cnt_inc;
            err_cnt_d         = err_cnt_inc;
            do_clear          = 1'b1;
          end else begin
            phase_d = (byte_i == 8'd0) ? PH_CRCL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_o.emit          = 1'b1;
          res_o.data_byte     = byte_i;
          res_o.payload_index = pcnt_q;
          pcnt_d              = pcnt_q + 8'd1;
          if (pcnt_d >= exp_q) begin
            phase_d = PH_CRCL;
          end
        end
        PH_CRCL: begin
          crc_d   = {8'd0, byte_i};
          phase_d = PH_CRCH;
        end
        PH_CRCH: begin
          crc_d   = {byte_i, crc_q[7:0]};
          phase_d = PH_END;
        end
        PH_END: begin
          res_o.emit = 1'b1;
          do_clear   = 1'b1;
          if (byte_i == cfg_i.end_marker) begin
            res_o.kind         = EV_FRAME;
            res_o.received_crc = crc_q;
          end else begin
            res_o.kind        = EV_ERROR;
            res_o.error_code  = ERR_BAD_END;
            res_o.error_total = err_cnt_inc;
            err_cnt_d         = err_cnt_inc;
          end
        end
        default: ;
      endcase
    end

    if (do_clear) begin
      phase_d = PH_HUNT;
      bytes_d = '0;
      exp_d   = '0;
      pcnt_d  = '0;
      addr_d  = '0;
      cmd_d   = '0;
      crc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      bytes_q   <= '0;
      exp_q     <= '0;
      pcnt_q    <= '0;
      addr_q    <= '0;
      cmd_q     <= '0;
      crc_q     <= '0;
      err_cnt_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bytes_q   <= bytes_d;
      exp_q     <= exp_d;
      pcnt_q    <= pcnt_d;
      addr_q    <= addr_d;
      cmd_q     <= cmd_d;
      crc_q     <= crc_d;
      err_cnt_q <= err_cnt_d;
    end
  end

  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> bytes_q == 9'd0 && pcnt_q == 8'd0 && exp_q == 8'd0)
    else $error("frame state not cleared while hunting");

  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> pcnt_q < exp_q)
    else $error("payload count reached length without leaving payload phase");

  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.emit && res_o.kind == EV_ERROR
      |=> err_cnt_q == $past(err_cnt_q) + 32'd1)
    else $error("error counter did not advance on a flagged error");

endmodule

// ===== sv/delimited_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_parser: byte-serial parser for delimited bus frames
// Hunts for the start marker, reads address, command, length, payload, CRC
// and end marker, emits payload bytes, frame completions and errors.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ---------------------------------
//  in       sink       in_valid_i / in_ready_o  rx_byte_i
//  out      source     out_valid_o/out_ready_i  event_kind_o .. error_total_o
//  cfg      sink       cfg_we_i (no wait)       cfg_index_i, cfg_wdata_i
//
//  One byte request is taken every cycle while the result register is free or
//  being emptied. A byte is held in the input register and then parsed into
//  the result register, which presents its result until it is taken.
//  The loop through the parse state register sets that rate.
//  Reset clears the parse state, the error counter, both valid flags and
//  the configuration to its defaults. When the result register holds a
//  request that is not taken, parsing pauses and the input register fills;
//  input ready then drops until the result moves on.
//
module delimited_frame_parser
  import dfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          event_kind_o,
  output logic [7:0]          data_byte_o,
  output logic [7:0]          payload_index_o,
  output logic [7:0]          frame_address_o,
  output logic [7:0]          frame_command_o,
  output logic [7:0]          frame_length_o,
  output logic [15:0]         received_crc_o,
  output logic [1:0]          error_code_o,
  output logic [31:0]         error_total_o,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic       step;

  // The staged byte is parsed whenever the result register is free or is
  // being emptied in this same cycle.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  dfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end

    // A parse step may only replace a result that is leaving or absent.
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res.emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (step && res.emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = 2'(res_q.kind);
  assign data_byte_o     = res_q.data_byte;
  assign payload_index_o = res_q.payload_index;
  assign frame_address_o = res_q.frame_address;
  assign frame_command_o = res_q.frame_command;
  assign frame_length_o  = res_q.frame_length;
  assign received_crc_o  = res_q.received_crc;
  assign error_code_o    = 2'(res_q.error_code);
  assign error_total_o   = res_q.error_total;

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q))
    else $error("staged byte lost while parsing was paused");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q))
    else $error("result request changed before it was taken");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input ready while both stages are held");

endmodule
